@@ rtl/core/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PAYLOAD_BITS  = 16;
  localparam int unsigned PRIORITY_BITS = 3;
  localparam int unsigned IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W         = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SHIFT,
    S_PUT,
    S_TAKE,
    S_HEAD,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic                     action;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [PAYLOAD_BITS-1:0]  payload;
  } spq_in_t;

  typedef struct packed {
    status_e                  status;
    logic [PAYLOAD_BITS-1:0]  removed_payload;
    logic                     head_valid;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [PAYLOAD_BITS-1:0]  head_payload;
    logic [CNT_W-1:0]         occupancy;
  } spq_out_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  pay;
  } entry_t;

  typedef struct packed {
    logic    latch_req;
    logic    idx_load;
    logic    idx_dec;
    logic    rd_en;
    logic    rd_head;
    logic    wr_shift;
    logic    wr_new;
    logic    cnt_inc;
    logic    pop;
    logic    st_en;
    status_e st_val;
    logic    out_load;
  } spq_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic is_full;
    logic is_empty;
    logic shift_more;
    logic idx_is_one;
    logic out_free;
  } spq_sts_t;

  function automatic logic [IDX_W-1:0] phys_addr(logic [IDX_W-1:0] head,
                                                 logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/spq_ctrl.sv @@
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_sts_t sts_i,
  output spq_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (sts_i.is_remove) begin
          state_d = sts_i.is_empty ? S_HEAD : S_TAKE;
        end else if (sts_i.is_full) begin
          state_d = S_HEAD;
        end else begin
          state_d = sts_i.is_empty ? S_PUT : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!sts_i.shift_more || sts_i.idx_is_one) begin
          state_d = S_PUT;
        end
      end
      S_PUT:  state_d = S_HEAD;
      S_TAKE: state_d = S_HEAD;
      S_HEAD: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.st_val = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_req = in_valid_i;
      end
      S_START: begin
        if (sts_i.is_remove) begin
          if (sts_i.is_empty) begin
            cmd_o.st_en  = 1'b1;
            cmd_o.st_val = ST_EMPTY;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_head = 1'b1;
          end
        end else if (sts_i.is_full) begin
          cmd_o.st_en  = 1'b1;
          cmd_o.st_val = ST_FULL;
        end else begin
          cmd_o.idx_load = 1'b1;
          cmd_o.rd_en    = !sts_i.is_empty;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_more) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.idx_dec  = 1'b1;
          cmd_o.rd_en    = !sts_i.idx_is_one;
        end
      end
      S_PUT: begin
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_TAKE: begin
        cmd_o.pop = 1'b1;
      end
      S_HEAD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_head = 1'b1;
      end
      S_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/spq_datapath.sv @@
`timescale 1ns / 1ps

module spq_datapath import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spq_in_t  in_data_i,
  input  spq_cmd_t cmd_i,
  output spq_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  entry_t                  mem [DEPTH];
  entry_t                  rdata_q;
  spq_in_t                 req_q;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [IDX_W-1:0]        head_q;
  logic [CNT_W-1:0]        count_q;
  status_e                 status_q;
  logic [PAYLOAD_BITS-1:0] removed_q;
  logic                    out_valid_q;
  spq_out_t                out_q;
  logic [IDX_W-1:0]        rd_idx;
  logic                    has_entry;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_load) begin
      idx_d = count_q[IDX_W-1:0];
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - 1'b1;
    end
  end

  assign rd_idx = cmd_i.rd_head ? '0 : idx_d - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= in_data_i;
    end
    idx_q <= idx_d;
    if (cmd_i.wr_shift) begin
      mem[phys_addr(head_q, idx_q)] <= rdata_q;
    end else if (cmd_i.wr_new) begin
      mem[phys_addr(head_q, idx_q)] <= '{prio: req_q.priority_req, pay: req_q.payload};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[phys_addr(head_q, rd_idx)];
    end
    if (cmd_i.latch_req) begin
      status_q  <= ST_OK;
      removed_q <= '0;
    end else begin
      if (cmd_i.st_en) begin
        status_q <= cmd_i.st_val;
      end
      if (cmd_i.pop) begin
        removed_q <= rdata_q.pay;
      end
    end
    if (cmd_i.out_load) begin
      out_q.status          <= status_q;
      out_q.removed_payload <= removed_q;
      out_q.head_valid      <= has_entry;
      out_q.head_priority   <= has_entry ? rdata_q.prio : '0;
      out_q.head_payload    <= has_entry ? rdata_q.pay : '0;
      out_q.occupancy       <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.pop) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.pop) begin
        head_q <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign has_entry = (count_q != '0);

  assign sts_o.is_remove  = (req_q.action == ACT_REMOVE);
  assign sts_o.is_full    = (count_q == CNT_W'(DEPTH));
  assign sts_o.is_empty   = !has_entry;
  assign sts_o.shift_more = (rdata_q.prio < req_q.priority_req);
  assign sts_o.idx_is_one = (idx_q == IDX_W'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/sorted_priority_queue.sv @@
`timescale 1ns / 1ps

// Bounded priority queue of DEPTH entries kept in service order in a ring
// memory; larger priority leaves first, equal priorities leave in arrival
// order. Each transaction is an insert or a remove and returns one result
// with status, removed payload, the new head and the occupancy. One
// transaction is processed at a time. An insert into a nonempty queue
// scans the stored entries from the back: each entry of lower priority
// moves back one slot, and the first entry of equal or higher priority
// ends the scan. The scan is paced by the single read and write port of
// the entry memory. The next transaction is accepted in the cycle after
// the result is loaded. A finished result waits in an output register
// while the next transaction is accepted.
module sorted_priority_queue import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
